### sv/mr_pkg.sv
package mr_pkg;

  localparam int DEFAULT_WIDTH = 64;
  localparam int FIELD_W       = 64;
  localparam int VERDICT_W     = 2;

  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam verdict_t VERDICT_PRIME     = 2'd0;
  localparam verdict_t VERDICT_COMPOSITE = 2'd1;
  localparam verdict_t VERDICT_REJECTED  = 2'd2;

endpackage

### sv/mr_in_if.sv
interface mr_in_if import mr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] candidate;
  logic [FIELD_W-1:0] witness;

  modport source (output valid, candidate, witness, input ready);
  modport sink (input valid, candidate, witness, output ready);
endinterface

### sv/mr_out_if.sv
interface mr_out_if import mr_pkg::*; ();
  logic     valid;
  logic     ready;
  verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

### sv/mr_mulmod.sv
module mr_mulmod import mr_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] res
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [CW-1:0]    cnt;
  logic             busy;

  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] n1;
  logic [WIDTH+1:0] n2;
  logic [WIDTH+1:0] t_red;
  logic [WIDTH-1:0] acc_next;

  // acc < n and x < n, so 2*acc + x stays below 3n: one of two subtractions reduces it
  always_comb begin
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    t  = {1'b0, acc, 1'b0} + {2'b00, (yr[WIDTH-1] ? xr : '0)};
    if (t >= n2) begin
      t_red = t - n2;
    end else if (t >= n1) begin
      t_red = t - n1;
    end else begin
      t_red = t;
    end
    acc_next = t_red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xr   <= x;
        yr   <= y;
        acc  <= '0;
        cnt  <= CW'(WIDTH - 1);
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        yr  <= yr << 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign res = acc;

endmodule

### sv/miller_rabin_round.sv
// One Miller-Rabin round on an odd candidate n with witness a.
// Input channel in_ch carries candidate and witness; only the low WIDTH bits
// of each are used. Output channel out_ch carries one verdict per item:
// 0 probable prime, 1 composite, 2 rejected (even, or 0, 1 or 2).
// The block works on one item at a time; in_ch.ready is high while idle.
// A shared modular multiplier works one multiplier bit per cycle. An item
// needs 1 + WIDTH + popcount(m) + j modular products, with n-1 = 2^k * m,
// m odd, and j <= k final squarings. Rejected candidates skip the
// arithmetic and go from idle straight to the done state.
// The verdict is held in an output register until taken. A new item is
// accepted while that verdict waits; if the next verdict is ready before
// out_ch drains, the block holds it and takes no further item.
// Synchronous reset returns to idle and drops any pending verdict.
module miller_rabin_round_unit import mr_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input logic clk,
  input logic rst,
  mr_in_if.sink in_ch,
  mr_out_if.source out_ch
);

  localparam int CW = $clog2(WIDTH);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FACTOR = 4'd1;
  localparam logic [3:0] ST_REDUCE = 4'd2;
  localparam logic [3:0] ST_SQR    = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_LOOP   = 4'd6;
  localparam logic [3:0] ST_LSQ    = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
  localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

  logic [3:0]       state;
  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] m;
  logic [CW-1:0]    ecnt;
  logic [CW-1:0]    kcnt;
  logic [WIDTH-1:0] op_x;
  logic [WIDTH-1:0] op_y;
  logic             mul_start;
  verdict_t         verdict_r;
  verdict_t         verdict_out;
  logic             out_valid;

  logic             mul_done;
  logic [WIDTH-1:0] mul_res;
  logic [WIDTH-1:0] cand_w;
  logic [WIDTH-1:0] n_minus_one;

  assign cand_w      = in_ch.candidate[WIDTH-1:0];
  assign n_minus_one = {n[WIDTH-1:1], 1'b0};

  mr_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (op_x),
    .y     (op_y),
    .n     (n),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            n    <= cand_w;
            a    <= in_ch.witness[WIDTH-1:0];
            m    <= {cand_w[WIDTH-1:1], 1'b0};
            kcnt <= '0;
            if (cand_w <= TWO || !cand_w[0]) begin
              verdict_r <= VERDICT_REJECTED;
              state     <= ST_DONE;
            end else begin
              state <= ST_FACTOR;
            end
          end
        end
        ST_FACTOR: begin
          // strip trailing zeros of n-1; it is nonzero, so this ends
          if (!m[0]) begin
            m    <= m >> 1;
            kcnt <= kcnt + 1'b1;
          end else begin
            // a mod n as 1 * a mod n
            op_x      <= ONE;
            op_y      <= a;
            mul_start <= 1'b1;
            state     <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            base      <= mul_res;
            r         <= ONE;
            ecnt      <= CW'(WIDTH - 1);
            op_x      <= ONE;
            op_y      <= ONE;
            mul_start <= 1'b1;
            state     <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (mul_done) begin
            r <= mul_res;
            if (m[WIDTH-1]) begin
              op_x      <= mul_res;
              op_y      <= base;
              mul_start <= 1'b1;
              state     <= ST_MUL;
            end else begin
              m <= m << 1;
              if (ecnt == '0) begin
                state <= ST_CHECK;
              end else begin
                ecnt      <= ecnt - 1'b1;
                op_x      <= mul_res;
                op_y      <= mul_res;
                mul_start <= 1'b1;
                state     <= ST_SQR;
              end
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            r <= mul_res;
            m <= m << 1;
            if (ecnt == '0) begin
              state <= ST_CHECK;
            end else begin
              ecnt      <= ecnt - 1'b1;
              op_x      <= mul_res;
              op_y      <= mul_res;
              mul_start <= 1'b1;
              state     <= ST_SQR;
            end
          end
        end
        ST_CHECK: begin
          if (r == ONE) begin
            verdict_r <= VERDICT_PRIME;
            state     <= ST_DONE;
          end else begin
            state <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (kcnt == '0) begin
            verdict_r <= VERDICT_COMPOSITE;
            state     <= ST_DONE;
          end else if (r == n_minus_one) begin
            verdict_r <= VERDICT_PRIME;
            state     <= ST_DONE;
          end else begin
            kcnt      <= kcnt - 1'b1;
            op_x      <= r;
            op_y      <= r;
            mul_start <= 1'b1;
            state     <= ST_LSQ;
          end
        end
        ST_LSQ: begin
          if (mul_done) begin
            r     <= mul_res;
            state <= ST_LOOP;
          end
        end
        ST_DONE: begin
          // hold until the output register is empty
          if (!out_valid) begin
            out_valid   <= 1'b1;
            verdict_out <= verdict_r;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready    = (state == ST_IDLE);
  assign out_ch.valid   = out_valid;
  assign out_ch.verdict = verdict_out;

endmodule

### sv/mr_checker.sv
module mr_checker import mr_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input verdict_t verdict
);

  // a stalled verdict holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_PRIME || verdict == VERDICT_COMPOSITE ||
                   verdict == VERDICT_REJECTED))
    else $error("undefined verdict code");

  // one item at a time: ready drops right after a beat is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("verdict repeated after beat");

  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind miller_rabin_round_unit mr_checker u_mr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .verdict   (out_ch.verdict)
);

### tb/mr_verdict_checker.sv
`timescale 1ns / 100ps

module mr_verdict_checker import mr_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  mr_in_if         in_ch,
  mr_out_if        out_ch,
  output int       mismatches,
  output int       verdicts_owed
);

  typedef struct {
    logic [FIELD_W-1:0] candidate;
    logic [FIELD_W-1:0] witness;
    verdict_t           verdict;
  } round_t;

  round_t verdicts_due [$];
  int     bad;
  int     reports;

  function automatic logic [FIELD_W-1:0] mul_mod(input logic [FIELD_W-1:0] x,
                                                 input logic [FIELD_W-1:0] y,
                                                 input logic [FIELD_W-1:0] n);
    logic [2*FIELD_W-1:0] prod;
    prod = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
    return FIELD_W'(prod % {{FIELD_W{1'b0}}, n});
  endfunction

  function automatic verdict_t round_verdict(input logic [FIELD_W-1:0] cand_raw,
                                             input logic [FIELD_W-1:0] wit_raw);
    logic [FIELD_W-1:0] mask;
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] n_less;
    int                 k;
    mask = (WIDTH >= FIELD_W) ? '1 : ((FIELD_W'(1) << WIDTH) - FIELD_W'(1));
    n = cand_raw & mask;
    a = wit_raw & mask;
    if (n <= FIELD_W'(2) || !n[0]) return VERDICT_REJECTED;
    n_less = n - FIELD_W'(1);
    m = n_less;
    k = 0;
    while (!m[0]) begin
      m = m >> 1;
      k++;
    end
    // square-and-multiply, exponent MSB first, base reduced mod n
    a = a % n;
    b = FIELD_W'(1);
    for (int i = FIELD_W - 1; i >= 0; i--) begin
      b = mul_mod(b, b, n);
      if (m[i]) b = mul_mod(b, a, n);
    end
    if (b == FIELD_W'(1)) return VERDICT_PRIME;
    for (int i = 0; i < k; i++) begin
      if (b == n_less) return VERDICT_PRIME;
      b = mul_mod(b, b, n);
    end
    return VERDICT_COMPOSITE;
  endfunction

  always @(posedge clk) begin
    round_t want;
    round_t got;
    if (rst) begin
      verdicts_due.delete();
      bad     = 0;
      reports = 0;
    end else begin
      // drain the output beat first: it never belongs to an item taken this edge
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          bad++;
          if (reports < 10)
            $display("%0t: verdict %0d with no item outstanding", $realtime, out_ch.verdict);
          reports++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_ch.verdict !== want.verdict) begin
            bad++;
            if (reports < 10)
              $display("%0t: n=%h a=%h verdict expected %0d, got %0d", $realtime,
                       want.candidate, want.witness, want.verdict, out_ch.verdict);
            reports++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got.candidate = in_ch.candidate;
        got.witness   = in_ch.witness;
        got.verdict   = round_verdict(in_ch.candidate, in_ch.witness);
        verdicts_due.push_back(got);
      end
    end
    mismatches    <= bad;
    verdicts_owed <= verdicts_due.size();
  end

endmodule

### tb/tb_miller_rabin_round_unit.sv
`timescale 1ns / 100ps

module tb_miller_rabin_round_unit import mr_pkg::*; ();

  localparam int WIDTH          = DEFAULT_WIDTH;
  localparam int RANDOM_ITEMS   = 80;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst;
  bit   calm;
  int   quiet;
  int   mismatches;
  int   verdicts_owed;

  mr_in_if  in_ch ();
  mr_out_if out_ch ();

  miller_rabin_round_unit #(.WIDTH(WIDTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mr_verdict_checker #(.WIDTH(WIDTH)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hold each beat until taken; optional gap before it
  task automatic offer(input logic [FIELD_W-1:0] cand, input logic [FIELD_W-1:0] wit);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.candidate <= cand;
    in_ch.witness   <= wit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // result side: stall a random number of cycles once a verdict shows up
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("tb_miller_rabin_round_unit: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [FIELD_W-1:0] cand;
    logic [FIELD_W-1:0] wit;
    int                 pick;
    int                 burst;
    int                 sent;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.candidate <= '0;
    in_ch.witness   <= '0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rejected candidates: 0, 1, 2 and even values
    offer(64'd0, 64'd5);
    offer(64'd1, 64'd1);
    offer(64'd2, 64'd1);
    offer(64'd4, 64'd3);
    offer(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
    // smallest legal candidate, witness zero and a multiple of n
    offer(64'd3, 64'd2);
    offer(64'd3, 64'd0);
    offer(64'd3, 64'd3);
    offer(64'd1000000007, 64'd2000000014);
    // witness above n, witness n-1, witness 1
    offer(64'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(64'd7, 64'd6);
    offer(64'd9, 64'd1);
    // Carmichael number and strong pseudoprimes, to base 2 and to base 7
    offer(64'd561, 64'd2);
    offer(64'd2047, 64'd2);
    offer(64'd3215031751, 64'd7);
    // large primes and composites, up to full width
    offer(64'hFFFF_FFFF_FFFF_FFC5, 64'd2);
    offer(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
    offer(64'h1FFF_FFFF_FFFF_FFFF, 64'h1FFF_FFFF_FFFF_FFFE);
    offer(64'hFFFF_FFFB, 64'd0);
    offer(64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        if (pick < 30) begin
          case ($urandom_range(0, 7))
            0: cand = 64'hFFFF_FFFF_FFFF_FFC5;
            1: cand = 64'hFFFF_FFFF_FFFF_FFAD;
            2: cand = 64'h7FFF_FFFF_FFFF_FFE7;
            3: cand = 64'h1FFF_FFFF_FFFF_FFFF;
            4: cand = 64'hFFFF_FFFB;
            5: cand = 64'd1000000007;
            6: cand = 64'd998244353;
            default: cand = 64'h1_0000_000F;
          endcase
        end else if (pick < 45) begin
          case ($urandom_range(0, 7))
            0: cand = 64'd2047;
            1: cand = 64'd1373653;
            2: cand = 64'd25326001;
            3: cand = 64'd3215031751;
            4: cand = 64'd3825123056546413051;
            5: cand = 64'd561;
            6: cand = 64'd1729;
            default: cand = (64'($urandom_range(3, 65535)) | 64'd1) *
                            (64'($urandom_range(3, 65535)) | 64'd1);
          endcase
        end else if (pick < 70) begin
          cand = {$urandom, $urandom} | 64'd1;
        end else begin
          cand = 64'($urandom_range(3, 65535)) | 64'd1;
        end
        case ($urandom_range(0, 3))
          0: wit = {$urandom, $urandom};
          1: wit = 64'($urandom_range(2, 7));
          default: wit = {$urandom, $urandom} % (cand - 64'd1) + 64'd1;
        endcase
        offer(cand, wit);
        sent++;
      end else begin
        // short run of rejected candidates: verdicts come back almost at once
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          if ($urandom_range(0, 1) == 1) cand = {$urandom, $urandom} & ~64'd1;
          else cand = 64'($urandom_range(0, 2));
          offer(cand, {$urandom, $urandom});
          sent++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_miller_rabin_round_unit: done, clean");
    end else begin
      $display("tb_miller_rabin_round_unit: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mr_pkg.sv
sv/mr_in_if.sv
sv/mr_out_if.sv
sv/mr_mulmod.sv
sv/miller_rabin_round.sv
sv/mr_checker.sv
tb/mr_verdict_checker.sv
tb/tb_miller_rabin_round_unit.sv
